// ===== src/assert_macros.svh =====
// Assertion helpers; every use samples on clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/zssd_pkg.sv =====
package zssd_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int OUT_OFF_W = 20;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_NEW     = 3'd1;
  localparam logic [2:0] KIND_MERGED  = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_NO_HDR  = 3'd4;
  localparam logic [2:0] KIND_ORDER   = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  localparam logic [7:0] PAD_END = 8'hff;
  localparam logic signed [11:0] LAST_BIN_INIT = -12'sd2;
  localparam logic [9:0] LEN_MAX = 10'h3ff;

  typedef logic [OFFSET_BITS-1:0] offset_t;

endpackage

// ===== src/zero_suppressed_sequence_decoder.sv =====
// Path: accepted words are registered in word_r, then decoded into the result register.
// Throughput: one item per cycle while out_stall is low; one compare/add pass per item.
// The result register frees a slot whenever it is empty or its item is taken.
// Reset (rst_n low, synchronous): both stages empty, decoder state cleared, last bin -2.
// in_bank_start clears the running state before its own word is decoded.
`include "assert_macros.svh"

module zero_suppressed_sequence_decoder import zssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_word,
  input  logic        in_bank_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [6:0]  out_row,
  output logic [7:0]  out_pad,
  output logic [8:0]  out_seq_index,
  output logic [9:0]  out_start_bin,
  output logic [9:0]  out_seq_length,
  output logic [19:0] out_adc_offset
);

  logic        in_valid_r;
  logic [15:0] word_r;
  logic        bank_r;

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [6:0]  row_r;
  logic [7:0]  pad_r;
  logic [8:0]  idx_r;
  logic [9:0]  start_r;
  logic [9:0]  len_r;
  logic [19:0] off_r;

  logic [6:0]         cur_row_r, cur_row_nxt, e_row;
  logic [7:0]         cur_pad_r, cur_pad_nxt, e_pad;
  logic               hdr_seen_r, hdr_seen_nxt, e_hdr;
  logic signed [11:0] last_bin_r, last_bin_nxt, e_last;
  logic [9:0]         old_start_r, old_start_nxt, e_old;
  logic [8:0]         seq_cnt_r, seq_cnt_nxt, e_cnt;
  logic [9:0]         open_start_r, open_start_nxt, e_ostart;
  logic [9:0]         open_len_r, open_len_nxt, e_olen;
  offset_t            adc_pos_r, adc_pos_nxt, e_adc;
  offset_t            open_adc_r, open_adc_nxt, e_oadc;
  logic               halted_r, halted_nxt, e_halt;

  logic [2:0]  kind_nxt;
  logic [7:0]  opad_nxt;
  logic [8:0]  idx_nxt;
  logic [9:0]  ostart_nxt;
  logic [9:0]  olen_nxt;
  offset_t     ooff_nxt;

  logic               slot_free;
  logic               commit;
  logic [9:0]         start;
  logic [4:0]         len;
  logic signed [12:0] start_s;
  logic signed [12:0] limit_s;
  logic [10:0]        len_sum;

  assign slot_free = !out_valid_r || !out_stall;
  assign commit    = in_valid_r && slot_free;
  assign in_stall  = in_valid_r && !slot_free;

  assign start   = word_r[15:6];
  assign len     = word_r[4:0];
  assign start_s = $signed({3'b000, start});
  assign limit_s = {e_last[11], e_last} + 13'sd1;
  assign len_sum = {1'b0, e_olen} + {6'd0, len};

  always_comb begin
    if (bank_r) begin
      e_row    = '0;
      e_pad    = '0;
      e_hdr    = 1'b0;
      e_last   = LAST_BIN_INIT;
      e_old    = '0;
      e_cnt    = '0;
      e_ostart = '0;
      e_olen   = '0;
      e_adc    = '0;
      e_oadc   = '0;
      e_halt   = 1'b0;
    end else begin
      e_row    = cur_row_r;
      e_pad    = cur_pad_r;
      e_hdr    = hdr_seen_r;
      e_last   = last_bin_r;
      e_old    = old_start_r;
      e_cnt    = seq_cnt_r;
      e_ostart = open_start_r;
      e_olen   = open_len_r;
      e_adc    = adc_pos_r;
      e_oadc   = open_adc_r;
      e_halt   = halted_r;
    end
  end

  always_comb begin
    cur_row_nxt    = e_row;
    cur_pad_nxt    = e_pad;
    hdr_seen_nxt   = e_hdr;
    last_bin_nxt   = e_last;
    old_start_nxt  = e_old;
    seq_cnt_nxt    = e_cnt;
    open_start_nxt = e_ostart;
    open_len_nxt   = e_olen;
    adc_pos_nxt    = e_adc;
    open_adc_nxt   = e_oadc;
    halted_nxt     = e_halt;
    kind_nxt       = KIND_IGNORED;
    opad_nxt       = e_pad;
    idx_nxt        = '0;
    ostart_nxt     = '0;
    olen_nxt       = '0;
    ooff_nxt       = e_adc;
    if (e_halt) begin
      kind_nxt = KIND_IGNORED;
    end else if (word_r[15]) begin
      cur_row_nxt = word_r[14:8];
      cur_pad_nxt = word_r[7:0];
      opad_nxt    = word_r[7:0];
      if (word_r[7:0] == PAD_END) begin
        halted_nxt = 1'b1;
        kind_nxt   = KIND_END;
      end else begin
        hdr_seen_nxt  = 1'b1;
        seq_cnt_nxt   = '0;
        old_start_nxt = '0;
        last_bin_nxt  = LAST_BIN_INIT;
        kind_nxt      = KIND_HEADER;
      end
    end else if (!e_hdr) begin
      halted_nxt = 1'b1;
      kind_nxt   = KIND_NO_HDR;
    end else if (start < e_old) begin
      halted_nxt = 1'b1;
      kind_nxt   = KIND_ORDER;
    end else begin
      if (start_s > limit_s) begin
        idx_nxt        = e_cnt;
        seq_cnt_nxt    = e_cnt + 9'd1;
        open_start_nxt = start;
        open_len_nxt   = {5'd0, len};
        open_adc_nxt   = e_adc;
        kind_nxt       = KIND_NEW;
      end else begin
        idx_nxt      = e_cnt - 9'd1;
        open_len_nxt = len_sum[10] ? LEN_MAX : len_sum[9:0];
        kind_nxt     = KIND_MERGED;
      end
      adc_pos_nxt   = e_adc + OFFSET_BITS'(len);
      last_bin_nxt  = 12'(start_s) + 12'(len) - 12'sd1;
      old_start_nxt = start;
      if (word_r[5]) begin
        cur_pad_nxt   = e_pad + 8'd1;
        seq_cnt_nxt   = '0;
        last_bin_nxt  = LAST_BIN_INIT;
        old_start_nxt = '0;
      end
      ostart_nxt = open_start_nxt;
      olen_nxt   = open_len_nxt;
      ooff_nxt   = open_adc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      word_r <= in_word;
      bank_r <= in_bank_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= '0;
      cur_pad_r    <= '0;
      hdr_seen_r   <= 1'b0;
      last_bin_r   <= LAST_BIN_INIT;
      old_start_r  <= '0;
      seq_cnt_r    <= '0;
      open_start_r <= '0;
      open_len_r   <= '0;
      adc_pos_r    <= '0;
      open_adc_r   <= '0;
      halted_r     <= 1'b0;
    end else if (commit) begin
      cur_row_r    <= cur_row_nxt;
      cur_pad_r    <= cur_pad_nxt;
      hdr_seen_r   <= hdr_seen_nxt;
      last_bin_r   <= last_bin_nxt;
      old_start_r  <= old_start_nxt;
      seq_cnt_r    <= seq_cnt_nxt;
      open_start_r <= open_start_nxt;
      open_len_r   <= open_len_nxt;
      adc_pos_r    <= adc_pos_nxt;
      open_adc_r   <= open_adc_nxt;
      halted_r     <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= in_valid_r;
    end
    if (commit) begin
      kind_r  <= kind_nxt;
      row_r   <= cur_row_nxt;
      pad_r   <= opad_nxt;
      idx_r   <= idx_nxt;
      start_r <= ostart_nxt;
      len_r   <= olen_nxt;
      off_r   <= OUT_OFF_W'(ooff_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_row        = row_r;
  assign out_pad        = pad_r;
  assign out_seq_index  = idx_r;
  assign out_start_bin  = start_r;
  assign out_seq_length = len_r;
  assign out_adc_offset = off_r;

  `ASSERT_IMPL(a_kind_range, out_valid_r, kind_r <= KIND_IGNORED)
  `ASSERT_IMPL(a_no_seq_fields, out_valid_r && kind_r != KIND_NEW && kind_r != KIND_MERGED,
               idx_r == 9'd0 && start_r == 10'd0 && len_r == 10'd0)
  `ASSERT_IMPL(a_new_len, out_valid_r && kind_r == KIND_NEW, len_r <= 10'd31)
  `ASSERT_NEXT(a_halt_set,
               commit && (kind_nxt == KIND_END || kind_nxt == KIND_NO_HDR ||
               kind_nxt == KIND_ORDER), halted_r)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

import zssd_pkg::*;

typedef struct {
  logic [2:0]  kind;
  logic [6:0]  row;
  logic [7:0]  pad;
  logic [8:0]  seq_index;
  logic [9:0]  start_bin;
  logic [9:0]  seq_length;
  logic [19:0] adc_offset;
} zs_record_t;

class zs_record_tracker;
  zs_record_t  pending_records[$];
  int          failures;
  logic [6:0]  row;
  logic [7:0]  pad;
  bit          have_header;
  int          prev_end;
  logic [9:0]  prev_start;
  logic [8:0]  seq_cnt;
  logic [9:0]  run_start;
  logic [9:0]  run_length;
  offset_t     adc_pos;
  offset_t     run_adc;
  bit          stopped;

  function new();
    failures = 0;
    clear_run();
  endfunction

  function void clear_run();
    row = '0;
    pad = '0;
    have_header = 1'b0;
    prev_end = int'(LAST_BIN_INIT);
    prev_start = '0;
    seq_cnt = '0;
    run_start = '0;
    run_length = '0;
    adc_pos = '0;
    run_adc = '0;
    stopped = 1'b0;
  endfunction

  function int pending();
    return pending_records.size();
  endfunction

  // decode one accepted word and queue the record it produces
  function void note_word(logic [15:0] w, logic bank_start);
    zs_record_t rec;
    logic [9:0] st;
    logic [4:0] ln;
    int         sum;
    if (bank_start) clear_run();
    rec = '{default: '0};
    rec.adc_offset = adc_pos;
    if (stopped) begin
      rec.kind = KIND_IGNORED;
      rec.pad = pad;
    end else if (w[15]) begin
      row = w[14:8];
      pad = w[7:0];
      rec.pad = pad;
      if (pad == PAD_END) begin
        stopped = 1'b1;
        rec.kind = KIND_END;
      end else begin
        have_header = 1'b1;
        seq_cnt = '0;
        prev_start = '0;
        prev_end = int'(LAST_BIN_INIT);
        rec.kind = KIND_HEADER;
      end
    end else if (!have_header) begin
      stopped = 1'b1;
      rec.kind = KIND_NO_HDR;
      rec.pad = pad;
    end else begin
      st = w[15:6];
      ln = w[4:0];
      rec.pad = pad;
      if (st < prev_start) begin
        stopped = 1'b1;
        rec.kind = KIND_ORDER;
      end else begin
        if (int'(st) > prev_end + 1) begin
          rec.kind = KIND_NEW;
          rec.seq_index = seq_cnt;
          seq_cnt = seq_cnt + 9'd1;
          run_start = st;
          run_length = 10'(ln);
          run_adc = adc_pos;
        end else begin
          rec.kind = KIND_MERGED;
          rec.seq_index = seq_cnt - 9'd1;
          sum = int'(run_length) + int'(ln);
          run_length = (sum > int'(LEN_MAX)) ? LEN_MAX : 10'(sum);
        end
        adc_pos = adc_pos + offset_t'(ln);
        prev_end = int'(st) + int'(ln) - 1;
        prev_start = st;
        if (w[5]) begin
          pad = pad + 8'd1;
          seq_cnt = '0;
          prev_end = int'(LAST_BIN_INIT);
          prev_start = '0;
        end
        rec.start_bin = run_start;
        rec.seq_length = run_length;
        rec.adc_offset = run_adc;
      end
    end
    rec.row = row;
    pending_records.push_back(rec);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function void check_record(zs_record_t got);
    zs_record_t want;
    if (pending_records.size() == 0) begin
      failures++;
      $error("record with no item outstanding: kind %0d", got.kind);
      return;
    end
    want = pending_records.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("row", want.row, got.row);
    compare_field("pad", want.pad, got.pad);
    compare_field("seq_index", want.seq_index, got.seq_index);
    compare_field("start_bin", want.start_bin, got.start_bin);
    compare_field("seq_length", want.seq_length, got.seq_length);
    compare_field("adc_offset", want.adc_offset, got.adc_offset);
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 60000;
  localparam int PHASE_ITEMS = 240;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [15:0] in_word = '0;
  logic        in_bank_start = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [6:0]  out_row;
  logic [7:0]  out_pad;
  logic [8:0]  out_seq_index;
  logic [9:0]  out_start_bin;
  logic [9:0]  out_seq_length;
  logic [19:0] out_adc_offset;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  zs_record_tracker tracker;

  zero_suppressed_sequence_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .in_bank_start(in_bank_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_row(out_row),
    .out_pad(out_pad),
    .out_seq_index(out_seq_index),
    .out_start_bin(out_start_bin),
    .out_seq_length(out_seq_length),
    .out_adc_offset(out_adc_offset)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_record('{out_kind, out_row, out_pad, out_seq_index, out_start_bin,
                             out_seq_length, out_adc_offset});
  end

  function automatic logic [15:0] hdr_word(int row, int pad);
    return {1'b1, 7'(row), 8'(pad)};
  endfunction

  function automatic logic [15:0] seq_word(int start, bit last, int len);
    return {10'(start), last, 5'(len)};
  endfunction

  task automatic push_word(logic [15:0] w, logic bank_start);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_bank_start <= bank_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(w, bank_start);
    items_sent++;
  endtask

  // hold off until every queued record has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic random_bank();
    int npads;
    int nseq;
    int lo;
    int hi_end;
    int s;
    int pick;
    bit flag;
    if ($urandom_range(0, 99) < 90)
      push_word(hdr_word($urandom_range(0, 127), $urandom_range(0, 254)), 1'b1);
    else
      push_word(16'($urandom), 1'b1);
    npads = $urandom_range(1, 5);
    repeat (npads) begin
      if ($urandom_range(0, 99) < 80)
        push_word(hdr_word($urandom_range(0, 127), $urandom_range(0, 254)), 1'b0);
      lo = 0;
      hi_end = -2;
      nseq = $urandom_range(0, 10);
      for (int i = 0; i < nseq; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3 && lo > 0)
          s = $urandom_range(0, lo - 1);
        else if (pick < 38 && hi_end > -2)
          s = $urandom_range(lo, (hi_end + 1 > 511) ? 511 : hi_end + 1);
        else
          s = hi_end + 2 + $urandom_range(0, 40);
        if (s > 511) break;
        flag = (i == nseq - 1) && ($urandom_range(0, 99) < 50);
        pick = $urandom_range(0, 31);
        push_word(seq_word(s, flag, pick), 1'b0);
        lo = s;
        hi_end = s + pick - 1;
        if (flag) begin
          lo = 0;
          hi_end = -2;
        end
      end
      if ($urandom_range(0, 99) < 5) push_word(16'($urandom), 1'b0);
    end
    if ($urandom_range(0, 99) < 70) begin
      push_word(hdr_word($urandom_range(0, 127), PAD_END), 1'b0);
      repeat ($urandom_range(0, 2)) push_word(16'($urandom), 1'b0);
    end
  endtask

  initial begin
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_word(seq_word(3, 0, 4), 1'b1);
    push_word(seq_word(0, 0, 0), 1'b0);
    push_word(hdr_word(0, 0), 1'b1);
    push_word(seq_word(0, 0, 0), 1'b0);
    push_word(seq_word(0, 0, 31), 1'b0);
    push_word(seq_word(0, 0, 31), 1'b0);
    push_word(seq_word(40, 0, 3), 1'b0);
    push_word(seq_word(43, 0, 2), 1'b0);
    push_word(seq_word(50, 1, 31), 1'b0);
    push_word(seq_word(2, 0, 7), 1'b0);
    push_word(hdr_word(127, 254), 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(seq_word(10, 0, 1), 1'b0);
    push_word(seq_word(5, 0, 1), 1'b0);
    push_word(hdr_word(3, 4), 1'b0);
    push_word(hdr_word(85, 170), 1'b1);
    push_word(seq_word(341, 0, 21), 1'b0);
    push_word(seq_word(100, 0, 0), 1'b1);
    push_word(hdr_word(127, PAD_END), 1'b1);
    push_word(16'h0000, 1'b0);
    push_word(hdr_word(1, 2), 1'b1);
    push_word(hdr_word(127, PAD_END), 1'b0);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 88;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 88;
        end
        default: begin
          idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      if (phase == 3) begin
        // wrap the per-pad sequence count, then merge into the wrapped slot
        push_word(hdr_word($urandom_range(0, 127), $urandom_range(0, 254)), 1'b1);
        for (int s = 0; s < 512; s++) push_word(seq_word(s, 1'b0, 0), 1'b0);
        push_word(seq_word(511, 1'b0, 5), 1'b0);
        push_word(seq_word(511, 1'b1, 0), 1'b0);
        // saturate the merged length
        push_word(hdr_word($urandom_range(0, 127), $urandom_range(0, 254)), 1'b1);
        repeat (40) push_word(seq_word(200, 1'b0, 31), 1'b0);
        push_word(seq_word(231, 1'b1, 17), 1'b0);
      end
      begin
        int target;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) random_bank();
      end
      settle();
    end

    stall_pct = 0;
    settle();
    repeat (8) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== zero_suppressed_sequence_decoder.f =====
+incdir+src
src/zssd_pkg.sv
src/zero_suppressed_sequence_decoder.sv
tb/testbench.sv
